// ===== hdl/irmq_pkg.sv =====
package irmq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam logic [31:0] IDENT_RESET = 32'hFFFF_FFFE;
  localparam logic [31:0] MAX_XFER_RESET = 32'd256;
  localparam int unsigned BYTE_SHIFT = 9;

  localparam logic [1:0] CFG_MERGE_ENABLE = 2'd0;
  localparam logic [1:0] CFG_MAX_XFER = 2'd1;
  localparam logic [1:0] CFG_UNIT_MISSING = 2'd2;

  localparam logic [2:0] ST_MERGED = 3'd0;
  localparam logic [2:0] ST_NEW = 3'd1;
  localparam logic [2:0] ST_ERROR = 3'd2;
  localparam logic [2:0] ST_TAKEN = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam logic FUNC_SUBMIT = 1'b0;
  localparam logic FUNC_TAKE = 1'b1;

  typedef struct packed {
    logic        func;
    logic        is_write;
    logic [63:0] start_sector;
    logic [63:0] end_sector;
    logic [31:0] transfer_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] request_id;
    logic        out_is_write;
    logic [63:0] out_start;
    logic [63:0] out_end;
    logic [31:0] out_length;
    logic        wake_consumer;
  } out_item_t;

  // one table entry as stored in the memory
  typedef struct packed {
    logic        wr;
    logic [63:0] start;
    logic [63:0] fin;
    logic [63:0] limit;
    logic [31:0] bytes;
    logic [31:0] ident;
  } entry_t;

  // outcome of checking one entry against a request
  typedef struct packed {
    logic   hit;
    entry_t upd;
  } merge_res_t;

endpackage

// ===== hdl/irmq_merge.sv =====
module irmq_merge (
  input  irmq_pkg::entry_t     ent,
  input  logic                 req_wr,
  input  logic [63:0]          req_start,
  input  logic [63:0]          req_end,
  input  logic [63:0]          req_limit,
  output irmq_pkg::merge_res_t res
);
  import irmq_pkg::*;

  logic [63:0] new_end;
  logic [63:0] span;

  always_comb begin
    res.hit = 1'b0;
    res.upd = ent;
    new_end = (req_end > ent.fin) ? req_end : ent.fin;
    if (ent.wr == req_wr) begin
      if (req_start >= ent.start) begin
        res.hit = (req_start <= ent.fin) && (req_end < ent.limit);
        res.upd.fin = new_end;
      end else begin
        res.hit = (req_end >= ent.start) && (req_end < ent.limit) && (ent.fin < req_limit);
        res.upd.start = req_start;
        res.upd.limit = req_limit;
        res.upd.fin = new_end;
      end
    end
    span = res.upd.fin - res.upd.start;
    // grow case without extension leaves bytes untouched
    if ((req_start >= ent.start) && !(req_end > ent.fin)) begin
      res.upd.bytes = ent.bytes;
    end else begin
      res.upd.bytes = 32'(span << BYTE_SHIFT);
    end
  end

endmodule

// ===== hdl/io_request_merge_queue.sv =====
// io_request_merge_queue: pending table of read/write sector-range
// transactions that coalesces overlapping submits into queued entries.
// Input channel (in_valid/in_stall/in_data): func 0 submits a range,
// func 1 takes the oldest pending entry. Output channel
// (out_valid/out_stall/out_data) returns exactly one result per input.
// Config port (cfg_we/cfg_index/cfg_wdata): 0 merge_enable,
// 1 max_transfer_blocks, 2 unit_missing; write only while idle.
// Entries live in one synchronous RAM with a registered read port. With
// merging on, pending entries are checked oldest first, each with a RAM
// read in S_READ, then compare and write-back in S_CHECK. A plain append
// writes the RAM from S_READ; a take reads the head entry via S_TAKE; an
// empty take or missing-unit error goes straight to S_DONE, which sets
// out_valid. The next transaction is accepted back in S_IDLE, once S_DONE
// has registered the result; no new transaction is taken during a scan.
// Reset (rst_n low, synchronous) empties the table, restores register
// defaults and sets the identifier counter to 0xFFFFFFFE. RAM contents are
// not cleared; valid tracking is by head/count. When the receiver stalls,
// out_data holds and the block waits before delivering the next result.
module io_request_merge_queue #(
  parameter int unsigned QUEUE_DEPTH = irmq_pkg::DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  irmq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output irmq_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_wdata
);
  import irmq_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW+CW:0] DEPTH_SUM = (AW+CW+1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CHECK = 5'b00100,
    S_TAKE  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic        merge_en_r;
  logic [31:0] max_xfer_r;
  logic        unit_missing_r;
  logic [AW-1:0] head_r, tail_r;
  logic [CW-1:0] count_r;
  logic [31:0] ident_r;
  logic [CW-1:0] scan_r;
  in_item_t    req_r;
  logic [63:0] limit_r;
  out_item_t   res_r;
  out_item_t   res_init;
  logic        out_valid_r;
  out_item_t   out_data_r;

  entry_t      mem [QUEUE_DEPTH];
  entry_t      rd_data_r;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  entry_t      wdata;
  logic        re;
  merge_res_t  mres;
  logic [AW-1:0] scan_slot;
  logic        in_acc, out_acc;
  logic [AW+CW:0] slot_sum;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  irmq_merge u_merge (
    .ent(rd_data_r), .req_wr(req_r.is_write), .req_start(req_r.start_sector),
    .req_end(req_r.end_sector), .req_limit(limit_r), .res(mres)
  );

  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    slot_sum = (AW+CW+1)'(head_r) + (AW+CW+1)'(scan_r);
    // head + scan stays below twice the depth, one subtract wraps it
    scan_slot = (slot_sum >= DEPTH_SUM) ? AW'(slot_sum - DEPTH_SUM) : AW'(slot_sum);
  end

  // result skeleton captured at accept; later states fill in the rest
  always_comb begin
    res_init = '0;
    if (in_data.func == FUNC_TAKE) begin
      res_init.status = (count_r == '0) ? ST_EMPTY : ST_TAKEN;
    end else if (unit_missing_r) begin
      res_init.status = ST_ERROR;
    end else begin
      res_init.status = ST_MERGED;
    end
  end

  always_comb begin
    state_nxt = state_r;
    we = 1'b0;
    waddr = tail_r;
    wdata = '0;
    re = 1'b0;
    raddr = scan_slot;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.func == FUNC_TAKE) begin
            state_nxt = (count_r == '0) ? S_DONE : S_TAKE;
            re = 1'b1;
            raddr = head_r;
          end else if (unit_missing_r) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (merge_en_r && (scan_r < count_r)) begin
          re = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_DONE;
          if (count_r < CW'(QUEUE_DEPTH)) begin
            we = 1'b1;
            waddr = tail_r;
            wdata.wr = req_r.is_write;
            wdata.start = req_r.start_sector;
            wdata.fin = req_r.end_sector;
            wdata.limit = limit_r;
            wdata.bytes = req_r.transfer_length;
            wdata.ident = ident_r + 32'd1;
          end
        end
      end
      S_CHECK: begin
        if (mres.hit) begin
          we = 1'b1;
          waddr = scan_slot;
          wdata = mres.upd;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_TAKE: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_acc) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      merge_en_r <= 1'b0;
      max_xfer_r <= MAX_XFER_RESET;
      unit_missing_r <= 1'b0;
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
      ident_r <= IDENT_RESET;
      out_valid_r <= 1'b0;
      scan_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MERGE_ENABLE: merge_en_r <= cfg_wdata[0];
          CFG_MAX_XFER: max_xfer_r <= cfg_wdata;
          CFG_UNIT_MISSING: unit_missing_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_acc && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          scan_r <= '0;
          if (in_acc) begin
            req_r <= in_data;
            limit_r <= in_data.start_sector + {32'd0, max_xfer_r};
            res_r <= res_init;
          end
        end
        S_READ: begin
          if (!(merge_en_r && (scan_r < count_r))) begin
            if (count_r < CW'(QUEUE_DEPTH)) begin
              res_r.status <= ST_NEW;
              res_r.slot <= 4'(tail_r);
              res_r.request_id <= ident_r + 32'd1;
              res_r.wake_consumer <= 1'b1;
              ident_r <= ident_r + 32'd1;
              tail_r <= (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
              count_r <= count_r + 1'b1;
            end else begin
              res_r.status <= ST_ERROR;
            end
          end
        end
        S_CHECK: begin
          if (mres.hit) begin
            res_r.status <= ST_MERGED;
            res_r.slot <= 4'(scan_slot);
            res_r.request_id <= rd_data_r.ident;
            res_r.wake_consumer <= 1'b1;
          end
          scan_r <= scan_r + 1'b1;
        end
        S_TAKE: begin
          res_r.status <= ST_TAKEN;
          res_r.slot <= 4'(head_r);
          res_r.request_id <= rd_data_r.ident;
          res_r.out_is_write <= rd_data_r.wr;
          res_r.out_start <= rd_data_r.start;
          res_r.out_end <= rd_data_r.fin;
          res_r.out_length <= rd_data_r.bytes;
          head_r <= (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
          count_r <= count_r - 1'b1;
        end
        S_DONE: begin
          if (!out_valid_r || out_acc) begin
            out_valid_r <= 1'b1;
            out_data_r <= res_r;
          end
        end
        default: ;
      endcase
    end
  end

  // count never exceeds table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH)) else $error("pending count overflow");
  // a RAM write lands only while the block is busy
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_READ || state_r == S_CHECK)) else $error("stray write");
  // accepted transaction always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE) else $error("accept lost");
  // a take on a non-empty table decrements count
  a_take_dec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TAKE |=> count_r == $past(count_r) - 1'b1) else $error("take count");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import irmq_pkg::*;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  io_request_merge_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow of the pending table and the config registers.
  logic        sh_merge;
  logic [31:0] sh_max_xfer;
  logic        sh_unit_missing;
  entry_t      sh_entry [DEPTH];
  logic        sh_valid [DEPTH];
  int          sh_head, sh_tail, sh_count;
  logic [31:0] sh_ident;

  out_item_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;   // no idling in the final stretch

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [31:0] span_bytes(input entry_t e);
    logic [63:0] d;
    d = (e.fin - e.start) << BYTE_SHIFT;
    return d[31:0];
  endfunction

  // Apply one transaction to the shadow table; return the result it must produce.
  function automatic out_item_t predict_queue(input in_item_t t);
    out_item_t r;
    logic [63:0] lim;
    int s;
    entry_t e;
    r = '0;
    if (t.func == FUNC_TAKE) begin
      if (sh_count == 0) begin
        r.status = ST_EMPTY;
        return r;
      end
      s = sh_head;
      e = sh_entry[s];
      r.status = ST_TAKEN;
      r.slot = s[3:0];
      r.request_id = e.ident;
      r.out_is_write = e.wr;
      r.out_start = e.start;
      r.out_end = e.fin;
      r.out_length = e.bytes;
      sh_valid[s] = 1'b0;
      sh_head = (s + 1) % DEPTH;
      sh_count--;
      return r;
    end
    if (sh_unit_missing) begin
      r.status = ST_ERROR;
      return r;
    end
    lim = t.start_sector + {32'd0, sh_max_xfer};
    if (sh_merge) begin
      for (int i = 0; i < sh_count; i++) begin
        bit hit;
        s = (sh_head + i) % DEPTH;
        e = sh_entry[s];
        hit = 1'b0;
        if (sh_valid[s] && e.wr == t.is_write) begin
          if (t.start_sector >= e.start) begin
            if (t.start_sector <= e.fin && t.end_sector < e.limit) begin
              hit = 1'b1;
              if (t.end_sector > e.fin) begin
                e.fin = t.end_sector;
                e.bytes = span_bytes(e);
              end
            end
          end else if (t.end_sector >= e.start && t.end_sector < e.limit &&
                       e.fin < lim) begin
            hit = 1'b1;
            e.start = t.start_sector;
            e.limit = lim;
            if (t.end_sector > e.fin) e.fin = t.end_sector;
            e.bytes = span_bytes(e);
          end
        end
        if (hit) begin
          sh_entry[s] = e;
          r.status = ST_MERGED;
          r.slot = s[3:0];
          r.request_id = e.ident;
          r.wake_consumer = 1'b1;
          return r;
        end
      end
    end
    if (sh_count >= DEPTH) begin
      r.status = ST_ERROR;
      return r;
    end
    s = sh_tail;
    sh_ident = sh_ident + 32'd1;
    e.wr = t.is_write;
    e.start = t.start_sector;
    e.fin = t.end_sector;
    e.limit = lim;
    e.bytes = t.transfer_length;
    e.ident = sh_ident;
    sh_entry[s] = e;
    sh_valid[s] = 1'b1;
    sh_tail = (s + 1) % DEPTH;
    sh_count++;
    r.status = ST_NEW;
    r.slot = s[3:0];
    r.request_id = sh_ident;
    r.wake_consumer = 1'b1;
    return r;
  endfunction

  // Result checker and receiver-side stall bursts.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result transaction", 64'd0, 64'd0);
      end else begin
        out_item_t w;
        w = expected_results.pop_front();
        if (out_data.status !== w.status)
          report_mismatch("status", 64'(out_data.status), 64'(w.status));
        if (out_data.slot !== w.slot)
          report_mismatch("slot", 64'(out_data.slot), 64'(w.slot));
        if (out_data.request_id !== w.request_id)
          report_mismatch("request_id", 64'(out_data.request_id), 64'(w.request_id));
        if (out_data.out_is_write !== w.out_is_write)
          report_mismatch("out_is_write", 64'(out_data.out_is_write), 64'(w.out_is_write));
        if (out_data.out_start !== w.out_start)
          report_mismatch("out_start", out_data.out_start, w.out_start);
        if (out_data.out_end !== w.out_end) report_mismatch("out_end", out_data.out_end, w.out_end);
        if (out_data.out_length !== w.out_length)
          report_mismatch("out_length", 64'(out_data.out_length), 64'(w.out_length));
        if (out_data.wake_consumer !== w.wake_consumer)
          report_mismatch("wake_consumer", 64'(out_data.wake_consumer), 64'(w.wake_consumer));
      end
    end
  end

  int stall_left = 0;
  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 16);
      out_stall <= 1'b1;
    end
  end

  // Watchdog: cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MERGE_ENABLE: sh_merge = val[0];
      CFG_MAX_XFER:     sh_max_xfer = val;
      CFG_UNIT_MISSING: sh_unit_missing = val[0];
      default: ;
    endcase
  endtask

  // Drains outstanding results, then lets the block settle before a config write.
  task automatic wait_idle();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Send one transaction; optional sender gap burst beforehand. Caller is at negedge.
  task automatic send_request(input in_item_t t, input bit allow_gap);
    if (allow_gap && !quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_data <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_queue(t));
    @(negedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Directed table. Rows with chk=1 carry the expected status typed in.
  typedef struct {
    in_item_t t;
    bit       chk;
    logic [2:0] want_status;
  } dir_row_t;

  function automatic in_item_t mk(input logic f, input logic w, input logic [63:0] s,
                                  input logic [63:0] e, input logic [31:0] l);
    in_item_t t;
    t.func = f; t.is_write = w; t.start_sector = s; t.end_sector = e; t.transfer_length = l;
    return t;
  endfunction

  // Well-formed submit near an existing base so merges happen often.
  function automatic in_item_t near_submit(input logic [63:0] base);
    in_item_t t;
    logic [63:0] s;
    s = base + $urandom_range(0, 300) - 150;
    t = mk(FUNC_SUBMIT, 1'($urandom_range(0, 1)), s, s + $urandom_range(0, 200), $urandom());
    return t;
  endfunction

  initial begin
    dir_row_t rows[$];
    logic [63:0] base;
    int n;
    sh_merge = 1'b0; sh_max_xfer = MAX_XFER_RESET; sh_unit_missing = 1'b0;
    sh_head = 0; sh_tail = 0; sh_count = 0; sh_ident = IDENT_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      sh_valid[i] = 1'b0;
      sh_entry[i] = '0;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, merging off: empty take, append with first identifier, extremes.
    rows.push_back('{mk(FUNC_TAKE, 0, 0, 0, 0), 1, ST_EMPTY});
    rows.push_back('{mk(FUNC_SUBMIT, 0, 100, 110, 32'd5120), 1, ST_NEW});
    rows.push_back('{mk(FUNC_SUBMIT, 0, 105, 120, 0), 1, ST_NEW});
    rows.push_back('{mk(FUNC_TAKE, 0, 0, 0, 0), 1, ST_TAKEN});
    rows.push_back('{mk(FUNC_TAKE, 0, 0, 0, 0), 1, ST_TAKEN});
    rows.push_back('{mk(FUNC_SUBMIT, 1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                        32'hFFFF_FFFF), 1, ST_NEW});
    rows.push_back('{mk(FUNC_SUBMIT, 1, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0), 1, ST_NEW});
    rows.push_back('{mk(FUNC_TAKE, 0, 0, 0, 0), 1, ST_TAKEN});
    rows.push_back('{mk(FUNC_TAKE, 0, 0, 0, 0), 1, ST_TAKEN});
    foreach (rows[i]) begin
      send_request(rows[i].t, 1'b0);
      if (expected_results[$].status !== rows[i].want_status)
        report_mismatch("directed status", 64'(expected_results[$].status),
                        64'(rows[i].want_status));
    end
    release_input();
    wait_idle();

    // Merging on: tail growth, front growth, direction miss, wrapping range.
    write_reg(CFG_MERGE_ENABLE, 32'd1);
    rows.delete();
    rows.push_back('{mk(FUNC_SUBMIT, 0, 1000, 1010, 0), 0, 0});
    rows.push_back('{mk(FUNC_SUBMIT, 0, 1005, 1050, 0), 0, 0});
    rows.push_back('{mk(FUNC_SUBMIT, 0, 990, 1020, 0), 0, 0});
    rows.push_back('{mk(FUNC_SUBMIT, 1, 1000, 1010, 0), 0, 0});
    rows.push_back('{mk(FUNC_SUBMIT, 0, 64'hFFFF_FFFF_FFFF_FFF0, 5, 0), 0, 0});
    rows.push_back('{mk(FUNC_SUBMIT, 0, 64'hFFFF_FFFF_FFFF_FFF8, 2, 0), 0, 0});
    foreach (rows[i]) send_request(rows[i].t, 1'b0);
    // Fill the table to force the full-table error.
    for (int i = 0; i < DEPTH + 2; i++)
      send_request(mk(FUNC_SUBMIT, 1, 64'd100000 * (i + 1), 64'd100000 * (i + 1), i), 1'b0);
    for (int i = 0; i < DEPTH + 1; i++) send_request(mk(FUNC_TAKE, 0, 0, 0, 0), 1'b0);
    release_input();
    wait_idle();

    // Missing unit: submits error, take still works.
    write_reg(CFG_UNIT_MISSING, 32'd1);
    send_request(mk(FUNC_SUBMIT, 0, 5, 6, 7), 1'b0);
    send_request(mk(FUNC_TAKE, 0, 0, 0, 0), 1'b0);
    release_input();
    wait_idle();
    write_reg(CFG_UNIT_MISSING, 32'd0);

    // Random phases across register settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_reg(CFG_MAX_XFER, 32'd0);
        1: write_reg(CFG_MAX_XFER, 32'hFFFF_FFFF);
        2: write_reg(CFG_MAX_XFER, 32'd256);
        3: write_reg(CFG_MERGE_ENABLE, 32'd0);
        4: begin
          write_reg(CFG_MERGE_ENABLE, 32'd1);
          write_reg(CFG_MAX_XFER, $urandom_range(1, 1000));
        end
        5: write_reg(CFG_UNIT_MISSING, 32'd1);
        6: write_reg(CFG_UNIT_MISSING, 32'd0);
        default: write_reg(CFG_MAX_XFER, $urandom());
      endcase
      if (ph == 7) quiet = 1'b1;
      base = ($urandom_range(0, 3) == 0) ? rand64() : {32'd0, $urandom_range(0, 4000)};
      n = (ph == 5) ? 40 : 260;
      for (int k = 0; k < n; k++) begin
        in_item_t t;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
          t = mk(FUNC_TAKE, 1'($urandom_range(0, 1)), rand64(), rand64(), $urandom());
        else if (pick < 85) t = near_submit(base);
        else t = mk(FUNC_SUBMIT, 1'($urandom_range(0, 1)), rand64(), rand64(), $urandom());
        send_request(t, 1'b1);
      end
      release_input();
      wait_idle();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Anything left over at the end is caught by wait_idle never returning
  // only if results are missing; the watchdog turns that into a failure.

endmodule

// ===== io_request_merge_queue.f =====
hdl/irmq_pkg.sv
hdl/irmq_merge.sv
hdl/io_request_merge_queue.sv
tb/tb_top.sv
